>>> design/bed_pkg.sv
// Shared types and constants of the button event detector.
// No dependencies; imported by bed_alu and button_event_detector.
`default_nettype none

package bed_pkg;

   // Sizes
   localparam int NUM_BUTTONS = 8;
   localparam int SLOT_W      = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = 4;

   // Held steps before auto-repeat starts
   localparam logic [15:0] REPEAT_DELAY_STEPS = 16'd100;

   // Event codes
   localparam logic [5:0] EV_NONE   = 6'd0;
   localparam logic [5:0] EV_DOWN   = 6'd1;
   localparam logic [5:0] EV_UP     = 6'd2;
   localparam logic [5:0] EV_LONG   = 6'd4;
   localparam logic [5:0] EV_CLICK  = 6'd8;
   localparam logic [5:0] EV_DOUBLE = 6'd16;
   localparam logic [5:0] EV_REPEAT = 6'd32;

   // Control register indexes
   localparam logic [2:0] CSR_SLOT_EN   = 3'd0;
   localparam logic [2:0] CSR_ACTIVE    = 3'd1;
   localparam logic [2:0] CSR_EV_EN     = 3'd2;
   localparam logic [2:0] CSR_DEBOUNCE  = 3'd3;
   localparam logic [2:0] CSR_LONG_MS   = 3'd4;
   localparam logic [2:0] CSR_DOUBLE_MS = 3'd5;
   localparam logic [2:0] CSR_REPEAT_MS = 3'd6;
   localparam logic [2:0] CSR_RPT_CODE  = 3'd7;

   // Request mode
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Double click phases
   localparam logic [1:0] DBL_IDLE  = 2'd0;
   localparam logic [1:0] DBL_ARMED = 2'd1;
   localparam logic [1:0] DBL_SEEN  = 2'd2;

   typedef enum logic [1:0] {
      ALU_ADD8,
      ALU_ADD16,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] cmp;
   } alu_ctl_type;

   typedef struct packed {
      logic [15:0] res;
      logic        a_ge;
      logic        res_ge;
   } alu_res_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] tick_ms;
      logic [7:0] raw_levels;
   } req_type;

   typedef struct packed {
      logic             event_valid;
      logic [2:0]       event_button;
      logic [5:0]       event_code;
      logic [CNT_W-1:0] pending_count;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/bed_alu.sv
// Shared saturating adder, wrapping subtractor and compare unit of the event detector.
// Depends on bed_pkg for the control and result structs.
`default_nettype none

module bed_alu (
   input  bed_pkg::alu_ctl_type ctl,
   output bed_pkg::alu_res_type res
);
   import bed_pkg::*;

   logic [8:0]  sum8;
   logic [16:0] sum16;
   logic [15:0] result;

   // Form both sums; saturate on carry out
   assign sum8  = {1'b0, ctl.a[7:0]} + {1'b0, ctl.b[7:0]};
   assign sum16 = {1'b0, ctl.a} + {1'b0, ctl.b};

   always_comb begin
      unique case (ctl.op)
         ALU_ADD8:  result = sum8[8] ? 16'h00FF : {8'h00, sum8[7:0]};
         ALU_ADD16: result = sum16[16] ? 16'hFFFF : sum16[15:0];
         ALU_SUB:   result = ctl.a - ctl.b;
         default:   result = ctl.a;
      endcase
   end

   // Compare both the operand and the result against the threshold
   assign res.res    = result;
   assign res.a_ge   = (ctl.a >= ctl.cmp);
   assign res.res_ge = (result >= ctl.cmp);

endmodule

`default_nettype wire

>>> design/button_event_detector.sv
// Button event detector: debounce, click / double / long / repeat detection
// and an event queue. Top level; depends on bed_pkg and bed_alu.
//
// Usage: a request transaction (req_valid/req_ready, req_payload) is either a
// tick (mode 0) carrying the elapsed milliseconds and the raw pin level of
// every slot, or a pop (mode 1) that takes the oldest queued event. Every
// request yields exactly one response transaction on rsp_valid/rsp_ready.
// A tick walks the slots in index order through one shared
// saturating adder/comparator: a disabled slot is only skipped, an enabled
// slot passes through the states for the events it raises (one queue write per
// cycle). req_ready stays low from acceptance until the response register
// is loaded, for a tick and for a pop alike.
// The control port (csr_we, csr_index, csr_wdata) writes a register at
// once; write it only while no request is in progress.
// Reset (synchronous, active high) restores the register defaults, clears
// all slot timers and empties the queue. If the receiver stalls, the
// response holds in its register; the next request is still accepted and
// processed, and waits only for the response register to free up.
// A full queue overwrites its oldest entry.
`default_nettype none

module button_event_detector (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bed_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bed_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import bed_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DEB, S_DOWN, S_DBL, S_LONG, S_RPT, S_RSUB,
      S_REL1, S_REL2, S_REL3, S_DTIM, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Control registers
   logic [NUM_BUTTONS-1:0] slot_en_ff, slot_en_in;
   logic [NUM_BUTTONS-1:0] active_ff, active_in;
   logic [5:0]  ev_en_ff, ev_en_in;
   logic [7:0]  deb_ms_ff, deb_ms_in;
   logic [15:0] long_ms_ff, long_ms_in;
   logic [15:0] dbl_ms_ff, dbl_ms_in;
   logic [15:0] rpt_ms_ff, rpt_ms_in;
   logic [5:0]  rpt_code_ff, rpt_code_in;

   // Per-slot state
   logic [NUM_BUTTONS-1:0] lvl_ff, lvl_in;
   logic [NUM_BUTTONS-1:0] armed_ff, armed_in;
   logic [7:0]  high_ff [NUM_BUTTONS];
   logic [7:0]  high_in [NUM_BUTTONS];
   logic [7:0]  low_ff [NUM_BUTTONS];
   logic [7:0]  low_in [NUM_BUTTONS];
   logic [15:0] ltim_ff [NUM_BUTTONS];
   logic [15:0] ltim_in [NUM_BUTTONS];
   logic [1:0]  phase_ff [NUM_BUTTONS];
   logic [1:0]  phase_in [NUM_BUTTONS];
   logic [15:0] dtim_ff [NUM_BUTTONS];
   logic [15:0] dtim_in [NUM_BUTTONS];

   // Shared repeat counter
   logic [15:0] hold_ff, hold_in;
   logic [15:0] rtime_ff, rtime_in;

   // Event queue
   logic [5:0]       qcode_ff [FIFO_DEPTH];
   logic [5:0]       qcode_in [FIFO_DEPTH];
   logic [2:0]       qbtn_ff [FIFO_DEPTH];
   logic [2:0]       qbtn_in [FIFO_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Sequencer registers
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              mode_ff, mode_in;
   logic [7:0]        ms_ff, ms_in;
   logic [7:0]        raw_ff, raw_in;
   logic              changed_ff, changed_in;
   logic              pressed_ff, pressed_in;
   logic              dblpush_ff, dblpush_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_pl_ff, rsp_pl_in;

   // Working signals
   alu_ctl_type alu_ctl;
   alu_res_type alu_res;
   logic        push_req;
   logic [5:0]  push_code;
   logic        do_push;
   logic        cur_raw, cur_act, cur_en, last_slot;
   logic        lvl_t, chg_t, prs_t;
   logic        en_long, en_double, en_repeat;

   bed_alu u_alu (
      .ctl (alu_ctl),
      .res (alu_res)
   );

   assign cur_raw   = raw_ff[slot_ff];
   assign cur_act   = active_ff[slot_ff];
   assign cur_en    = slot_en_ff[slot_ff];
   assign last_slot = (slot_ff == SLOT_W'(NUM_BUTTONS - 1));
   assign en_long   = ((ev_en_ff & EV_LONG) != '0);
   assign en_double = ((ev_en_ff & EV_DOUBLE) != '0);
   assign en_repeat = ((ev_en_ff & EV_REPEAT) != '0);
   assign do_push   = push_req && ((ev_en_ff & push_code) != '0);

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_pl_ff;

   always_comb begin
      // Hold by default
      state_in    = state_ff;
      slot_en_in  = slot_en_ff;
      active_in   = active_ff;
      ev_en_in    = ev_en_ff;
      deb_ms_in   = deb_ms_ff;
      long_ms_in  = long_ms_ff;
      dbl_ms_in   = dbl_ms_ff;
      rpt_ms_in   = rpt_ms_ff;
      rpt_code_in = rpt_code_ff;
      lvl_in      = lvl_ff;
      armed_in    = armed_ff;
      high_in     = high_ff;
      low_in      = low_ff;
      ltim_in     = ltim_ff;
      phase_in    = phase_ff;
      dtim_in     = dtim_ff;
      hold_in     = hold_ff;
      rtime_in    = rtime_ff;
      qcode_in    = qcode_ff;
      qbtn_in     = qbtn_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      count_in    = count_ff;
      slot_in     = slot_ff;
      mode_in     = mode_ff;
      ms_in       = ms_ff;
      raw_in      = raw_ff;
      changed_in  = changed_ff;
      pressed_in  = pressed_ff;
      dblpush_in  = dblpush_ff;
      rsp_pl_in   = rsp_pl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      push_req    = 1'b0;
      push_code   = EV_NONE;
      lvl_t       = 1'b0;
      chg_t       = 1'b0;
      prs_t       = 1'b0;
      alu_ctl     = '{op: ALU_ADD16, a: '0, b: '0, cmp: '0};

      unique case (state_ff)
         // Capture the transaction
         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_payload.mode;
               ms_in   = req_payload.tick_ms;
               raw_in  = req_payload.raw_levels;
               slot_in = '0;
               state_in = (req_payload.mode == MODE_POP) ? S_DONE : S_DEB;
            end
         end

         // Debounce the raw level of the current slot
         S_DEB: begin
            if (!cur_en) begin
               if (last_slot) begin
                  state_in = S_DONE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = S_DEB;
               end
            end else begin
               alu_ctl.op  = ALU_ADD8;
               alu_ctl.a   = {8'h00, (cur_raw ? high_ff[slot_ff] : low_ff[slot_ff])};
               alu_ctl.b   = {8'h00, ms_ff};
               alu_ctl.cmp = {8'h00, deb_ms_ff};
               lvl_t = lvl_ff[slot_ff];
               if (cur_raw) begin
                  low_in[slot_ff] = '0;
                  if (!alu_res.a_ge) begin
                     high_in[slot_ff] = alu_res.res[7:0];
                  end else if (!lvl_t) begin
                     chg_t = 1'b1;
                     lvl_t = 1'b1;
                  end
               end else begin
                  high_in[slot_ff] = '0;
                  if (!alu_res.a_ge) begin
                     low_in[slot_ff] = alu_res.res[7:0];
                  end else if (lvl_t) begin
                     chg_t = 1'b1;
                     lvl_t = 1'b0;
                  end
               end
               prs_t = (lvl_t == cur_act);
               lvl_in[slot_ff] = lvl_t;
               changed_in = chg_t;
               pressed_in = prs_t;
               if (prs_t) begin
                  state_in = chg_t ? S_DOWN : S_LONG;
               end else begin
                  state_in = chg_t ? S_REL1 : S_DTIM;
               end
            end
         end

         // Press edge: down event, arm long press and double click
         S_DOWN: begin
            push_req   = 1'b1;
            push_code  = EV_DOWN;
            dblpush_in = 1'b0;
            if (en_long) begin
               armed_in[slot_ff] = 1'b1;
               ltim_in[slot_ff]  = '0;
            end
            if (en_double) begin
               if (phase_ff[slot_ff] == DBL_IDLE) begin
                  phase_in[slot_ff] = DBL_ARMED;
                  dtim_in[slot_ff]  = '0;
               end else if (phase_ff[slot_ff] == DBL_ARMED) begin
                  phase_in[slot_ff] = DBL_SEEN;
                  dblpush_in = 1'b1;
               end
            end
            state_in = (en_double && phase_ff[slot_ff] == DBL_ARMED) ? S_DBL : S_LONG;
         end

         S_DBL: begin
            push_req  = 1'b1;
            push_code = EV_DOUBLE;
            state_in  = S_LONG;
         end

         // Advance the long press timer
         S_LONG: begin
            if (armed_ff[slot_ff]) begin
               alu_ctl.op  = ALU_ADD16;
               alu_ctl.a   = ltim_ff[slot_ff];
               alu_ctl.b   = {8'h00, ms_ff};
               alu_ctl.cmp = long_ms_ff;
               ltim_in[slot_ff] = alu_res.res;
               if (alu_res.res_ge) begin
                  push_req  = 1'b1;
                  push_code = EV_LONG;
                  armed_in[slot_ff] = 1'b0;
               end
            end
            state_in = en_repeat ? S_RPT : S_DTIM;
         end

         // Count the repeat delay, then the repeat period
         S_RPT: begin
            alu_ctl.op  = ALU_ADD16;
            alu_ctl.cmp = rpt_ms_ff;
            state_in    = S_DTIM;
            if (hold_ff < REPEAT_DELAY_STEPS) begin
               alu_ctl.a = hold_ff;
               alu_ctl.b = 16'd1;
               hold_in   = alu_res.res;
            end else begin
               alu_ctl.a = rtime_ff;
               alu_ctl.b = {8'h00, ms_ff};
               rtime_in  = alu_res.res;
               if (alu_res.res_ge) begin
                  state_in = S_RSUB;
               end
            end
         end

         S_RSUB: begin
            alu_ctl.op = ALU_SUB;
            alu_ctl.a  = rtime_ff;
            alu_ctl.b  = rpt_ms_ff;
            rtime_in   = alu_res.res;
            push_req   = 1'b1;
            push_code  = rpt_code_ff;
            state_in   = S_DTIM;
         end

         // Release edge: clear repeat, click on an armed long press unless double click is enabled
         S_REL1: begin
            hold_in  = '0;
            rtime_in = '0;
            if (armed_ff[slot_ff]) begin
               armed_in[slot_ff] = 1'b0;
               push_req  = !en_double;
               push_code = EV_CLICK;
            end
            state_in = S_REL2;
         end

         S_REL2: begin
            push_req  = !en_long && !en_double;
            push_code = EV_CLICK;
            state_in  = S_REL3;
         end

         S_REL3: begin
            push_req  = 1'b1;
            push_code = EV_UP;
            if (phase_ff[slot_ff] == DBL_SEEN) begin
               phase_in[slot_ff] = DBL_IDLE;
            end
            state_in = S_DTIM;
         end

         // Double click window; a lapsed window with the button up is a click
         S_DTIM: begin
            if (phase_ff[slot_ff] == DBL_ARMED) begin
               alu_ctl.op  = ALU_ADD16;
               alu_ctl.a   = dtim_ff[slot_ff];
               alu_ctl.b   = {8'h00, ms_ff};
               alu_ctl.cmp = dbl_ms_ff;
               dtim_in[slot_ff] = alu_res.res;
               if (alu_res.res_ge) begin
                  push_req  = !armed_ff[slot_ff] && !pressed_ff;
                  push_code = EV_CLICK;
                  phase_in[slot_ff] = DBL_IDLE;
               end
            end
            if (last_slot) begin
               state_in = S_DONE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_DEB;
            end
         end

         // Load the response once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pl_in    = '0;
               if (mode_ff == MODE_POP && count_ff != '0) begin
                  rsp_pl_in.event_valid  = 1'b1;
                  rsp_pl_in.event_button = qbtn_ff[rp_ff];
                  rsp_pl_in.event_code   = qcode_ff[rp_ff];
                  rp_in    = (rp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
               rsp_pl_in.pending_count = count_in;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Queue write; overwrite the oldest entry when full
      if (do_push) begin
         qcode_in[wp_ff] = push_code;
         qbtn_in[wp_ff]  = slot_ff;
         wp_in = (wp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (count_ff < CNT_W'(FIFO_DEPTH)) begin
            count_in = count_ff + 1'b1;
         end
      end

      // Control register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOT_EN: begin
               for (int s = 0; s < NUM_BUTTONS; s++) begin
                  if (csr_wdata[s] && !slot_en_ff[s]) begin
                     lvl_in[s] = ~active_ff[s];
                  end
               end
               slot_en_in = csr_wdata[NUM_BUTTONS-1:0];
            end
            CSR_ACTIVE: begin
               active_in = csr_wdata[NUM_BUTTONS-1:0];
               lvl_in    = ~csr_wdata[NUM_BUTTONS-1:0];
            end
            CSR_EV_EN:     ev_en_in    = csr_wdata[5:0];
            CSR_DEBOUNCE:  deb_ms_in   = csr_wdata[7:0];
            CSR_LONG_MS:   long_ms_in  = csr_wdata;
            CSR_DOUBLE_MS: dbl_ms_in   = csr_wdata;
            CSR_REPEAT_MS: rpt_ms_in   = csr_wdata;
            CSR_RPT_CODE:  rpt_code_in = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_en_ff   <= '0;
         active_ff    <= '0;
         ev_en_ff     <= 6'd63;
         deb_ms_ff    <= 8'd20;
         long_ms_ff   <= 16'd1000;
         dbl_ms_ff    <= 16'd300;
         rpt_ms_ff    <= 16'd100;
         rpt_code_ff  <= EV_CLICK;
         lvl_ff       <= '1;
         armed_ff     <= '0;
         for (int s = 0; s < NUM_BUTTONS; s++) begin
            high_ff[s]  <= '0;
            low_ff[s]   <= '0;
            ltim_ff[s]  <= '0;
            phase_ff[s] <= DBL_IDLE;
            dtim_ff[s]  <= '0;
         end
         hold_ff      <= '0;
         rtime_ff     <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         changed_ff   <= 1'b0;
         pressed_ff   <= 1'b0;
         dblpush_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_en_ff   <= slot_en_in;
         active_ff    <= active_in;
         ev_en_ff     <= ev_en_in;
         deb_ms_ff    <= deb_ms_in;
         long_ms_ff   <= long_ms_in;
         dbl_ms_ff    <= dbl_ms_in;
         rpt_ms_ff    <= rpt_ms_in;
         rpt_code_ff  <= rpt_code_in;
         lvl_ff       <= lvl_in;
         armed_ff     <= armed_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         ltim_ff      <= ltim_in;
         phase_ff     <= phase_in;
         dtim_ff      <= dtim_in;
         hold_ff      <= hold_in;
         rtime_ff     <= rtime_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         changed_ff   <= changed_in;
         pressed_ff   <= pressed_in;
         dblpush_ff   <= dblpush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // Payload registers
      qcode_ff  <= qcode_in;
      qbtn_ff   <= qbtn_in;
      mode_ff   <= mode_in;
      ms_ff     <= ms_in;
      raw_ff    <= raw_in;
      rsp_pl_ff <= rsp_pl_in;
   end

   // Queue fill never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("event queue count exceeds depth");

   // A returned event always carries a nonzero code
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pl_ff.event_valid) |-> (rsp_pl_ff.event_code != EV_NONE))
      else $error("returned event has no code");

   // A pop of a nonempty queue removes exactly one entry
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && mode_ff == MODE_POP && count_ff != '0
       && (!rsp_valid_ff || rsp_ready))
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not decrement queue count");

   // A double click push follows only from a press edge that saw one
   a_dbl_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DBL) |-> (dblpush_ff && changed_ff && pressed_ff))
      else $error("double click step without a second press");

   // A tick never reports an event
   a_tick_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && mode_ff == MODE_TICK && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && !rsp_pl_ff.event_valid))
      else $error("tick response carries an event");

endmodule

`default_nettype wire
